// ----- hdl/hsncf_pkg.sv -----
// Shared types and constants for the hard-sphere next-collision finder.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package hsncf_pkg;

    // default store split: movers first, then walls
    localparam int MOVER_COUNT_DEF = 64;
    localparam int WALL_COUNT_DEF  = 128;

    // item fields
    localparam int COORD_W  = 32;   // Q16.16 words
    localparam int INDEX_W  = 8;
    localparam int TIME_W   = 32;
    localparam int FRAC_W   = 16;

    // stream widths
    localparam int S_DATA_W = INDEX_W + 7 * COORD_W;   // 232, whole bytes
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = TIME_W + INDEX_W;        // 40, whole bytes
    localparam int M_USER_W = 2;

    // pair arithmetic widths (differences are COORD_W+1 bits)
    localparam int A_W       = 2 * (COORD_W + 1);      // |dv|^2, unsigned
    localparam int B_W       = 2 * (COORD_W + 1) + 1;  // dr.dv, signed
    localparam int C_W       = 2 * (COORD_W + 1) + 2;  // |dr|^2 - R^2, signed
    localparam int OP_W      = C_W;                    // multiplier operand
    localparam int PROD_W    = 2 * OP_W;
    localparam int D_W       = PROD_W - 2;             // discriminant, signed
    localparam int ROOT_W    = OP_W;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int MUL_DIGIT = 4;                      // multiplier bits per cycle

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef struct packed {
        logic [COORD_W-1:0] radius;
        logic [COORD_W-1:0] vz;
        logic [COORD_W-1:0] vy;
        logic [COORD_W-1:0] vx;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } entry_t;

    typedef struct packed {
        entry_t             sphere;
        logic [INDEX_W-1:0] entry_index;
    } in_item_t;

    // product sequence of one pair
    typedef enum logic [3:0] {
        MUL_DVX,
        MUL_DVY,
        MUL_DVZ,
        MUL_DRVX,
        MUL_DRVY,
        MUL_DRVZ,
        MUL_DRX,
        MUL_DRY,
        MUL_DRZ,
        MUL_RR,
        MUL_BB,
        MUL_AC
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QCHK,
        ST_SELF,
        ST_SEEK,
        ST_PAIR,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_CHECK,
        ST_SQRT_WAIT,
        ST_PICK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RESULT,
        ST_BAD
    } state_t;

    typedef struct packed {
        logic    write;
        logic    capture;
        logic    rd_self;
        logic    load_self;
        logic    scan_init;
        logic    rd_partner;
        logic    scan_next;
        logic    diff;
        logic    mul_start;
        mul_op_t mul_op;
        logic    accum;
        logic    sqrt_start;
        logic    pick;
        logic    div_start;
        logic    update;
        logic    out_load;
        logic    out_bad;
    } cmd_t;

    typedef struct packed {
        logic q_ok;
        logic j_done;
        logic j_skip;
        logic mul_done;
        logic a_zero;
        logic d_neg;
        logic sqrt_done;
        logic has_root;
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/hsncf_mul.sv -----
// Iterative signed multiplier, MUL_DIGIT multiplier bits per cycle.
// Depends on hsncf_pkg.
`default_nettype none

module hsncf_mul (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [hsncf_pkg::OP_W-1:0]   a,
    input  wire logic signed [hsncf_pkg::OP_W-1:0]   b,
    output logic                                     done,
    output logic signed [hsncf_pkg::PROD_W-1:0]      prod
);

    localparam int OP_W   = hsncf_pkg::OP_W;
    localparam int PROD_W = hsncf_pkg::PROD_W;
    localparam int DIG    = hsncf_pkg::MUL_DIGIT;
    localparam int STEPS  = (OP_W + DIG - 1) / DIG;
    localparam int CNT_W  = $clog2(STEPS + 1);

    logic [PROD_W-1:0]        mcand_reg;
    logic [OP_W-1:0]          mplier_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic                     neg_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic [OP_W-1:0]   mag_a;
    logic [OP_W-1:0]   mag_b;
    logic [PROD_W-1:0] partial;

    assign mag_a   = a[OP_W-1] ? OP_W'(-a) : OP_W'(a);
    assign mag_b   = b[OP_W-1] ? OP_W'(-b) : OP_W'(b);
    assign partial = PROD_W'(mcand_reg * PROD_W'(mplier_reg[DIG-1:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                    cnt_reg <= cnt_reg - 1'b1;
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= PROD_W'(mag_a);
            mplier_reg <= mag_b;
            acc_reg    <= '0;
            neg_reg    <= a[OP_W-1] ^ b[OP_W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                acc_reg    <= acc_reg + partial;
                mcand_reg  <= mcand_reg << DIG;
                mplier_reg <= mplier_reg >> DIG;
            end
            else
                prod_reg <= neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- hdl/hsncf_sqrt.sv -----
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on hsncf_pkg.
`default_nettype none

module hsncf_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [hsncf_pkg::RAD_W-1:0]   radicand,
    output logic                               done,
    output logic [hsncf_pkg::ROOT_W-1:0]       root
);

    localparam int ROOT_W = hsncf_pkg::ROOT_W;
    localparam int RAD_W  = hsncf_pkg::RAD_W;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [ROOT_W+3:0]   rem_sh;
    logic [ROOT_W+3:0]   trial;
    logic                ge;

    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= (ROOT_W+2)'(ge ? rem_sh - trial : rem_sh);
            root_reg <= {root_reg[ROOT_W-2:0], ge};
            rad_reg  <= rad_reg << 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ----- hdl/hsncf_dp.sv -----
// Datapath: sphere store, valid bits, pair setup, accumulators, root pick,
// time division, best-so-far tracking and output register.
// Depends on hsncf_pkg, hsncf_mul and hsncf_sqrt.
`default_nettype none

module hsncf_dp #(
    parameter int MOVER_COUNT = hsncf_pkg::MOVER_COUNT_DEF,
    parameter int WALL_COUNT  = hsncf_pkg::WALL_COUNT_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire hsncf_pkg::cmd_t                      cmd,
    input  wire hsncf_pkg::in_item_t                  in_item,
    output hsncf_pkg::status_t                        status,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [hsncf_pkg::M_DATA_W-1:0]            m_tdata,
    output logic [hsncf_pkg::M_USER_W-1:0]            m_tuser
);

    localparam int TOTAL   = MOVER_COUNT + WALL_COUNT;
    localparam int AW      = $clog2(TOTAL);
    localparam int INDEX_W = hsncf_pkg::INDEX_W;
    localparam int CW      = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam int COORD_W = hsncf_pkg::COORD_W;
    localparam int A_W     = hsncf_pkg::A_W;
    localparam int B_W     = hsncf_pkg::B_W;
    localparam int C_W     = hsncf_pkg::C_W;
    localparam int D_W     = hsncf_pkg::D_W;
    localparam int OP_W    = hsncf_pkg::OP_W;
    localparam int PROD_W  = hsncf_pkg::PROD_W;
    localparam int ROOT_W  = hsncf_pkg::ROOT_W;
    localparam int RAD_W   = hsncf_pkg::RAD_W;
    localparam int TIME_W  = hsncf_pkg::TIME_W;
    localparam int FRAC_W  = hsncf_pkg::FRAC_W;
    localparam int N_W     = ROOT_W + 2;
    localparam int DCNT_W  = $clog2(TIME_W + 1);

    function automatic logic signed [COORD_W:0] sdiff(input logic [COORD_W-1:0] p,
                                                      input logic [COORD_W-1:0] q);
        return $signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q});
    endfunction

    // store and valid bits
    hsncf_pkg::entry_t mem [TOTAL];
    logic [TOTAL-1:0]  valid_reg;
    hsncf_pkg::entry_t rd_data_reg;
    hsncf_pkg::entry_t self_reg;

    logic [CW-1:0]     wr_ext;
    logic              wr_ok;
    logic [CW-1:0]     q_reg;
    logic [AW:0]       j_reg;
    logic [AW-1:0]     rd_addr;

    // pair terms
    logic signed [COORD_W:0] dr_reg [3];
    logic signed [COORD_W:0] dv_reg [3];
    logic [COORD_W:0]        rs_reg;
    logic [A_W-1:0]          a_acc;
    logic signed [B_W-1:0]   b_acc;
    logic signed [C_W-1:0]   c_acc;
    logic signed [D_W-1:0]   d_acc;

    logic signed [OP_W-1:0]   mul_a;
    logic signed [OP_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    logic                     mul_done;
    logic [ROOT_W-1:0]        sqrt_root;
    logic                     sqrt_done;

    // root pick
    logic signed [N_W-1:0] s_ext;
    logic signed [N_W-1:0] b_ext;
    logic signed [N_W-1:0] n1;
    logic signed [N_W-1:0] n2;
    logic                  n1_pos;
    logic                  n2_pos;
    logic                  has_root_reg;
    logic [ROOT_W-1:0]     n_reg;

    // division
    logic [A_W-1:0]    div_p_reg;
    logic [TIME_W-1:0] div_low_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic              div_busy_reg;
    logic              div_done_reg;
    logic [TIME_W-1:0] time_reg;
    logic              div_sat;
    logic [A_W:0]      div_p2;
    logic              div_ge;

    // best so far
    logic              found_reg;
    logic [TIME_W-1:0] best_reg;
    logic [AW-1:0]     partner_reg;

    // output register
    logic               m_tvalid_reg;
    logic               m_found_reg;
    logic               m_bad_reg;
    logic [TIME_W-1:0]  m_time_reg;
    logic [INDEX_W-1:0] m_partner_reg;

    assign wr_ext  = CW'(in_item.entry_index);
    assign wr_ok   = wr_ext < CW'(TOTAL);
    assign rd_addr = cmd.rd_self ? q_reg[AW-1:0] : j_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_ok)
            mem[wr_ext[AW-1:0]] <= in_item.sphere;
        if (cmd.rd_self || cmd.rd_partner)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.write && wr_ok)
            valid_reg[wr_ext[AW-1:0]] <= 1'b1;
    end

    // query index, scan pointer, mover entry, pair setup
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            q_reg <= CW'(in_item.entry_index);
        if (cmd.load_self)
            self_reg <= rd_data_reg;
        if (cmd.diff)
        begin
            dr_reg[0] <= sdiff(self_reg.x, rd_data_reg.x);
            dr_reg[1] <= sdiff(self_reg.y, rd_data_reg.y);
            dr_reg[2] <= sdiff(self_reg.z, rd_data_reg.z);
            dv_reg[0] <= sdiff(self_reg.vx, rd_data_reg.vx);
            dv_reg[1] <= sdiff(self_reg.vy, rd_data_reg.vy);
            dv_reg[2] <= sdiff(self_reg.vz, rd_data_reg.vz);
            rs_reg    <= {1'b0, self_reg.radius} + {1'b0, rd_data_reg.radius};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            j_reg <= '0;
        else if (cmd.scan_init)
            j_reg <= '0;
        else if (cmd.scan_next)
            j_reg <= j_reg + 1'b1;
    end

    // operand select for the shared multiplier
    always_comb
    begin
        case (cmd.mul_op)
            hsncf_pkg::MUL_DVX:  begin mul_a = OP_W'(dv_reg[0]); mul_b = OP_W'(dv_reg[0]); end
            hsncf_pkg::MUL_DVY:  begin mul_a = OP_W'(dv_reg[1]); mul_b = OP_W'(dv_reg[1]); end
            hsncf_pkg::MUL_DVZ:  begin mul_a = OP_W'(dv_reg[2]); mul_b = OP_W'(dv_reg[2]); end
            hsncf_pkg::MUL_DRVX: begin mul_a = OP_W'(dr_reg[0]); mul_b = OP_W'(dv_reg[0]); end
            hsncf_pkg::MUL_DRVY: begin mul_a = OP_W'(dr_reg[1]); mul_b = OP_W'(dv_reg[1]); end
            hsncf_pkg::MUL_DRVZ: begin mul_a = OP_W'(dr_reg[2]); mul_b = OP_W'(dv_reg[2]); end
            hsncf_pkg::MUL_DRX:  begin mul_a = OP_W'(dr_reg[0]); mul_b = OP_W'(dr_reg[0]); end
            hsncf_pkg::MUL_DRY:  begin mul_a = OP_W'(dr_reg[1]); mul_b = OP_W'(dr_reg[1]); end
            hsncf_pkg::MUL_DRZ:  begin mul_a = OP_W'(dr_reg[2]); mul_b = OP_W'(dr_reg[2]); end
            hsncf_pkg::MUL_RR:   begin mul_a = OP_W'(rs_reg);    mul_b = OP_W'(rs_reg);    end
            hsncf_pkg::MUL_BB:   begin mul_a = OP_W'(b_acc);     mul_b = OP_W'(b_acc);     end
            default:             begin mul_a = OP_W'(a_acc);     mul_b = OP_W'(c_acc);     end
        endcase
    end

    hsncf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // A, B, C, D accumulation; partial sums wrap but the finals fit
    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            a_acc <= '0;
            b_acc <= '0;
            c_acc <= '0;
        end
        else if (cmd.accum)
        begin
            case (cmd.mul_op)
                hsncf_pkg::MUL_DVX,
                hsncf_pkg::MUL_DVY,
                hsncf_pkg::MUL_DVZ:  a_acc <= a_acc + mul_prod[A_W-1:0];
                hsncf_pkg::MUL_DRVX,
                hsncf_pkg::MUL_DRVY,
                hsncf_pkg::MUL_DRVZ: b_acc <= b_acc + $signed(mul_prod[B_W-1:0]);
                hsncf_pkg::MUL_DRX,
                hsncf_pkg::MUL_DRY,
                hsncf_pkg::MUL_DRZ:  c_acc <= c_acc + $signed(mul_prod[C_W-1:0]);
                hsncf_pkg::MUL_RR:   c_acc <= c_acc - $signed(mul_prod[C_W-1:0]);
                hsncf_pkg::MUL_BB:   d_acc <= $signed(mul_prod[D_W-1:0]);
                default:             d_acc <= d_acc - $signed(mul_prod[D_W-1:0]);
            endcase
        end
    end

    hsncf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (RAD_W'($unsigned(d_acc))),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // roots: n2 = -B - S preferred, n1 = S - B only when n2 < 0
    assign s_ext  = $signed(N_W'(sqrt_root));
    assign b_ext  = N_W'(b_acc);
    assign n1     = s_ext - b_ext;
    assign n2     = -b_ext - s_ext;
    assign n1_pos = !n1[N_W-1] && (n1 != '0);
    assign n2_pos = !n2[N_W-1] && (n2 != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            has_root_reg <= 1'b0;
        else if (cmd.pick)
            has_root_reg <= n2_pos || (n1_pos && n2[N_W-1]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pick)
            n_reg <= n2_pos ? ROOT_W'(n2) : ROOT_W'(n1);
    end

    // time = floor(n * 2^16 / A), saturating at all ones; restoring division, one bit per cycle
    assign div_sat = (A_W+FRAC_W)'(n_reg) >= {a_acc, {FRAC_W{1'b0}}};
    assign div_p2  = {div_p_reg, div_low_reg[TIME_W-1]};
    assign div_ge  = div_p2 >= (A_W+1)'(a_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                div_busy_reg <= !div_sat;
                div_done_reg <= div_sat;
                div_cnt_reg  <= DCNT_W'(TIME_W);
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_cnt_reg == DCNT_W'(1))
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            time_reg    <= div_sat ? '1 : '0;
            div_p_reg   <= A_W'(n_reg >> FRAC_W);
            div_low_reg <= {n_reg[FRAC_W-1:0], {(TIME_W-FRAC_W){1'b0}}};
        end
        else if (div_busy_reg)
        begin
            div_p_reg   <= A_W'(div_ge ? div_p2 - (A_W+1)'(a_acc) : div_p2);
            div_low_reg <= div_low_reg << 1;
            time_reg    <= {time_reg[TIME_W-2:0], div_ge};
        end
    end

    // best so far; strict compare keeps the lowest index on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (cmd.scan_init)
            found_reg <= 1'b0;
        else if (cmd.update)
            found_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            best_reg    <= '0;
            partner_reg <= '0;
        end
        else if (cmd.update && (!found_reg || (time_reg < best_reg)))
        begin
            best_reg    <= time_reg;
            partner_reg <= j_reg[AW-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_bad_reg     <= cmd.out_bad;
            m_found_reg   <= !cmd.out_bad && found_reg;
            m_time_reg    <= (!cmd.out_bad && found_reg) ? best_reg : '0;
            m_partner_reg <= (!cmd.out_bad && found_reg) ? INDEX_W'(partner_reg) : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_partner_reg, m_time_reg};
    assign m_tuser  = {m_bad_reg, m_found_reg};

    always_comb
    begin
        status.q_ok      = (q_reg < CW'(MOVER_COUNT)) && valid_reg[q_reg[AW-1:0]];
        status.j_done    = j_reg == (AW+1)'(TOTAL);
        status.j_skip    = (CW'(j_reg) == q_reg) || !valid_reg[j_reg[AW-1:0]];
        status.mul_done  = mul_done;
        status.a_zero    = a_acc == '0;
        status.d_neg     = d_acc[D_W-1];
        status.sqrt_done = sqrt_done;
        status.has_root  = has_root_reg;
        status.div_done  = div_done_reg;
        status.out_busy  = m_tvalid_reg && !m_tready;
    end

`ifndef SYNTHESIS
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(m_tvalid_reg && !m_tready))
        else $error("result register overwritten before transfer");

    a_div_needs_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> has_root_reg)
        else $error("division started without a positive root");

    a_update_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> found_reg)
        else $error("found flag not set after a pair update");

    a_read_valid_partner: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_partner |-> (!status.j_done && !status.j_skip))
        else $error("partner read of skipped or out-of-range entry");
`endif

endmodule

`default_nettype wire

// ----- hdl/hsncf_ctrl.sv -----
// Controller state machine: input handshake, scan sequencing, product
// sequence and result hand-off. Depends on hsncf_pkg.
`default_nettype none

module hsncf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire hsncf_pkg::action_t    action,
    input  wire hsncf_pkg::status_t    status,
    output logic                       s_tready,
    output hsncf_pkg::cmd_t            cmd
);

    hsncf_pkg::state_t  state_reg;
    hsncf_pkg::state_t  state_next;
    hsncf_pkg::mul_op_t op_reg;
    hsncf_pkg::mul_op_t op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hsncf_pkg::ST_IDLE;
            op_reg    <= hsncf_pkg::MUL_DVX;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.mul_op = op_reg;
        state_next = state_reg;
        op_next    = op_reg;
        s_tready   = 1'b0;
        case (state_reg)
            hsncf_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (action == hsncf_pkg::ACT_LOAD)
                        cmd.write = 1'b1;
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = hsncf_pkg::ST_QCHK;
                    end
                end
            end
            hsncf_pkg::ST_QCHK:
            begin
                if (!status.q_ok)
                    state_next = hsncf_pkg::ST_BAD;
                else
                begin
                    cmd.rd_self = 1'b1;
                    state_next  = hsncf_pkg::ST_SELF;
                end
            end
            hsncf_pkg::ST_SELF:
            begin
                cmd.load_self = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = hsncf_pkg::ST_SEEK;
            end
            hsncf_pkg::ST_SEEK:
            begin
                if (status.j_done)
                    state_next = hsncf_pkg::ST_RESULT;
                else if (status.j_skip)
                    cmd.scan_next = 1'b1;
                else
                begin
                    cmd.rd_partner = 1'b1;
                    state_next     = hsncf_pkg::ST_PAIR;
                end
            end
            hsncf_pkg::ST_PAIR:
            begin
                cmd.diff   = 1'b1;
                op_next    = hsncf_pkg::MUL_DVX;
                state_next = hsncf_pkg::ST_MUL_GO;
            end
            hsncf_pkg::ST_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = hsncf_pkg::ST_MUL_WAIT;
            end
            hsncf_pkg::ST_MUL_WAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.accum = 1'b1;
                    if (op_reg == hsncf_pkg::MUL_AC)
                        state_next = hsncf_pkg::ST_CHECK;
                    else
                    begin
                        op_next    = hsncf_pkg::mul_op_t'(op_reg + 4'd1);
                        state_next = hsncf_pkg::ST_MUL_GO;
                    end
                end
            end
            hsncf_pkg::ST_CHECK:
            begin
                if (status.a_zero || status.d_neg)
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = hsncf_pkg::ST_SEEK;
                end
                else
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = hsncf_pkg::ST_SQRT_WAIT;
                end
            end
            hsncf_pkg::ST_SQRT_WAIT:
            begin
                if (status.sqrt_done)
                    state_next = hsncf_pkg::ST_PICK;
            end
            hsncf_pkg::ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = hsncf_pkg::ST_DIV_GO;
            end
            hsncf_pkg::ST_DIV_GO:
            begin
                if (!status.has_root)
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = hsncf_pkg::ST_SEEK;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = hsncf_pkg::ST_DIV_WAIT;
                end
            end
            hsncf_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.update    = 1'b1;
                    cmd.scan_next = 1'b1;
                    state_next    = hsncf_pkg::ST_SEEK;
                end
            end
            hsncf_pkg::ST_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = hsncf_pkg::ST_IDLE;
                end
            end
            hsncf_pkg::ST_BAD:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_bad  = 1'b1;
                    state_next   = hsncf_pkg::ST_IDLE;
                end
            end
            default:
                state_next = hsncf_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/hard_sphere_next_collision_finder.sv -----
// Top level of the hard-sphere next-collision finder.
// Depends on hsncf_pkg, hsncf_ctrl and hsncf_dp (with hsncf_mul, hsncf_sqrt).
`default_nettype none

// The block keeps a store of MOVER_COUNT moving spheres (indices from 0)
// followed by WALL_COUNT wall spheres. A load transfer (tuser = 0) writes one
// entry and marks it valid in the same cycle; indices past the store are
// dropped, and a load gives no result. A query transfer (tuser = 1) names a
// mover; the block reads it, then walks every other valid entry in index
// order and solves |dr + dv t| = r1 + r2 exactly in wide integers, keeping
// the earliest strictly positive time (Q16.16, saturating at all ones, lowest
// index on ties). The query gives exactly one result transfer: found, time
// and partner, or bad_query when the index is not a valid mover. An evaluated
// pair runs through the shared iterative multiplier (twelve products), then,
// if A is nonzero and D is not negative, the square root and, if a positive
// root is found, the divider, so a query's run time grows with the number of
// valid partners and the store size. Input transfers are taken only between
// queries; a finished result sits in the output register so loads and the
// next query go on while it waits.
module hard_sphere_next_collision_finder #(
    parameter int MOVER_COUNT = hsncf_pkg::MOVER_COUNT_DEF,
    parameter int WALL_COUNT  = hsncf_pkg::WALL_COUNT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // entry_index[7:0], pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, sphere_radius
    input  wire logic [hsncf_pkg::S_DATA_W-1:0]    s_tdata,
    // action
    input  wire logic [hsncf_pkg::S_USER_W-1:0]    s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // collision_time[31:0], partner_index[39:32]
    output logic [hsncf_pkg::M_DATA_W-1:0]         m_tdata,
    // found[0], bad_query[1]
    output logic [hsncf_pkg::M_USER_W-1:0]         m_tuser
);

    hsncf_pkg::in_item_t in_item;
    hsncf_pkg::action_t  action;
    hsncf_pkg::cmd_t     cmd;
    hsncf_pkg::status_t  status;

    // tdata maps straight onto the item struct: index low, radius high
    assign in_item = s_tdata;
    assign action  = hsncf_pkg::action_t'(s_tuser[0]);

    hsncf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .action   (action),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    hsncf_dp #(
        .MOVER_COUNT (MOVER_COUNT),
        .WALL_COUNT  (WALL_COUNT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_item  (in_item),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for hard_sphere_next_collision_finder.
// Depends on hsncf_pkg and the block's RTL; holds its own exact pair solver.
`timescale 1ns / 1ps

module testbench;

    localparam int MOVERS      = hsncf_pkg::MOVER_COUNT_DEF;
    localparam int ENTRIES     = hsncf_pkg::MOVER_COUNT_DEF + hsncf_pkg::WALL_COUNT_DEF;
    localparam int ONE         = 32'h0001_0000;  // 1.0 in Q16.16
    localparam int RANDOM_ITEMS = 1200;
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [hsncf_pkg::S_DATA_W-1:0] s_tdata;
    logic [hsncf_pkg::S_USER_W-1:0] s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [hsncf_pkg::M_DATA_W-1:0] m_tdata;
    logic [hsncf_pkg::M_USER_W-1:0] m_tuser;

    hard_sphere_next_collision_finder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    typedef struct {
        logic        found;
        logic [31:0] ctime;
        logic [7:0]  partner;
        logic        bad;
    } answer_t;

    typedef struct {
        hsncf_pkg::action_t  act;
        hsncf_pkg::in_item_t item;
        bit                  typed;    // answer below is written out by hand
        answer_t             ans;
    } stim_row_t;

    // mirror of the sphere store
    logic [31:0] sx[ENTRIES], sy[ENTRIES], sz[ENTRIES];
    logic [31:0] svx[ENTRIES], svy[ENTRIES], svz[ENTRIES], srad[ENTRIES];
    bit          occupied[ENTRIES];

    answer_t   pending_answers[$];
    stim_row_t directed[$];
    int        errors;
    longint    cycles;

    // ------------------------------------------------------------------
    // exact pair solver in 160-bit two's complement, exact like the block
    // ------------------------------------------------------------------
    function automatic logic [31:0] scaled_quotient(logic [159:0] n, logic [159:0] a);
        logic [159:0] num;
        num = n << 16;
        if (num >= (a << 32))
            return 32'hFFFF_FFFF;
        return 32'(num / a);
    endfunction

    function automatic bit contact_time(int p, int q, output logic [31:0] t);
        logic signed [159:0] dx, dy, dz, ux, uy, uz, rs;
        logic signed [159:0] a, b, c, d, s, cand, n1, n2;
        dx = $signed(sx[p]) - $signed(sx[q]);
        dy = $signed(sy[p]) - $signed(sy[q]);
        dz = $signed(sz[p]) - $signed(sz[q]);
        ux = $signed(svx[p]) - $signed(svx[q]);
        uy = $signed(svy[p]) - $signed(svy[q]);
        uz = $signed(svz[p]) - $signed(svz[q]);
        rs = 160'(srad[p]) + 160'(srad[q]);
        t  = '0;
        a  = ux * ux + uy * uy + uz * uz;
        b  = dx * ux + dy * uy + dz * uz;
        c  = dx * dx + dy * dy + dz * dz - rs * rs;
        if (a == 0)
            return 0;
        d = b * b - a * c;
        if (d < 0)
            return 0;
        // bitwise floor square root, 68 result bits
        s = 0;
        for (int i = 67; i >= 0; i--)
        begin
            cand = s | (160'sd1 << i);
            if (cand * cand <= d)
                s = cand;
        end
        n1 = s - b;
        n2 = -b - s;
        if (n2 > 0)
        begin
            t = scaled_quotient(n2, a);
            return 1;
        end
        if (n1 > 0 && n2 < 0)
        begin
            t = scaled_quotient(n1, a);
            return 1;
        end
        return 0;
    endfunction

    // applies one accepted transfer to the mirror; queries give an answer
    function automatic void apply_transfer(hsncf_pkg::action_t act, hsncf_pkg::in_item_t it);
        answer_t     ans;
        logic [31:0] t;
        int          idx;
        idx = it.entry_index;
        if (act == hsncf_pkg::ACT_LOAD)
        begin
            if (idx < ENTRIES)
            begin
                sx[idx]   = it.sphere.x;
                sy[idx]   = it.sphere.y;
                sz[idx]   = it.sphere.z;
                svx[idx]  = it.sphere.vx;
                svy[idx]  = it.sphere.vy;
                svz[idx]  = it.sphere.vz;
                srad[idx] = it.sphere.radius;
                occupied[idx] = 1;
            end
            return;
        end
        ans = '{found: 0, ctime: 0, partner: 0, bad: 0};
        if (idx >= MOVERS || !occupied[idx])
            ans.bad = 1;
        else
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (j == idx || !occupied[j])
                    continue;
                // strict compare keeps the lowest index on ties
                if (contact_time(idx, j, t) && (!ans.found || t < ans.ctime))
                begin
                    ans.found   = 1;
                    ans.ctime   = t;
                    ans.partner = 8'(j);
                end
            end
        pending_answers.push_back(ans);
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic hsncf_pkg::entry_t make_sphere(int x, int y, int z,
                                                      int vx, int vy, int vz,
                                                      logic [31:0] r);
        hsncf_pkg::entry_t e;
        e.x = x; e.y = y; e.z = z;
        e.vx = vx; e.vy = vy; e.vz = vz;
        e.radius = r;
        return e;
    endfunction

    function automatic void add_row(hsncf_pkg::action_t act, int idx, hsncf_pkg::entry_t e);
        stim_row_t row;
        row.act = act;
        row.item.entry_index = 8'(idx);
        row.item.sphere = e;
        row.typed = 0;
        row.ans = '{found: 0, ctime: 0, partner: 0, bad: 0};
        directed.push_back(row);
    endfunction

    function automatic void add_typed_query(int idx, answer_t ans);
        add_row(hsncf_pkg::ACT_QUERY, idx, '0);
        directed[$].typed = 1;
        directed[$].ans = ans;
    endfunction

    function automatic logic [31:0] span(int half);
        return 32'($signed($urandom_range(0, 2 * half)) - half);
    endfunction

    // mostly near-field spheres that meet; some fully random words
    function automatic hsncf_pkg::entry_t random_sphere();
        if ($urandom_range(0, 9) < 7)
            return make_sphere(span(1 << 21), span(1 << 21), span(1 << 21),
                               span(1 << 18), span(1 << 18), span(1 << 18),
                               $urandom_range(0, 1 << 19));
        return make_sphere($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom());
    endfunction

    // small fixed entry set (eight indices) keeps each query short; other picks are past the store
    function automatic int pick_load_index();
        int set_idx[8] = '{0, 1, 2, 3, 63, 64, 65, 191};
        if ($urandom_range(0, 99) < 85)
            return set_idx[$urandom_range(0, 7)];
        return $urandom_range(ENTRIES, 255);
    endfunction

    function automatic int pick_query_index();
        int movers[5] = '{0, 1, 2, 3, 63};
        if ($urandom_range(0, 9) < 7)
            return movers[$urandom_range(0, 4)];
        return $urandom_range(0, 255);
    endfunction

    // ------------------------------------------------------------------
    // clock, reset, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n    = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // result side: random stalls, compare against the oldest answer
    // ------------------------------------------------------------------
    initial
    begin
        int  gap;
        int  count;
        bit  calm;
        count = 0;
        calm  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (count % 16 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                m_tready <= 0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            count++;
        end
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
                report("unexpected result", {m_tuser, m_tdata}, 0);
            else
            begin
                want = pending_answers.pop_front();
                if (m_tuser[0] !== want.found)
                    report("found", m_tuser[0], want.found);
                if (m_tdata[31:0] !== want.ctime)
                    report("collision_time", m_tdata[31:0], want.ctime);
                if (m_tdata[39:32] !== want.partner)
                    report("partner_index", m_tdata[39:32], want.partner);
                if (m_tuser[1] !== want.bad)
                    report("bad_query", m_tuser[1], want.bad);
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    int  sent;
    bit  steady;

    task automatic send(hsncf_pkg::action_t act, hsncf_pkg::in_item_t it, bit typed,
                        answer_t ans);
        int gap;
        @(negedge clk);
        if (sent % 64 == 0)
            steady = ($urandom_range(0, 3) == 0);
        gap = steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= act;
        s_tdata  <= it;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
        if (typed)
            pending_answers.push_back(ans);
        else
            apply_transfer(act, it);
    endtask

    initial
    begin
        hsncf_pkg::in_item_t it;
        hsncf_pkg::action_t  act;
        answer_t             none;
        none = '{found: 0, ctime: 0, partner: 0, bad: 0};
        errors = 0;
        cycles = 0;
        sent   = 0;
        steady = 0;

        // directed part
        add_typed_query(0, '{found: 0, ctime: 0, partner: 0, bad: 1});   // empty store
        add_row(hsncf_pkg::ACT_LOAD, 0, make_sphere(0, 0, 0, ONE, 0, 0, ONE));
        add_row(hsncf_pkg::ACT_LOAD, 64, make_sphere(10 * ONE, 0, 0, 0, 0, 0, ONE));
        // head-on at distance 10, contact at 8.0
        add_typed_query(0, '{found: 1, ctime: 32'h0008_0000, partner: 64, bad: 0});
        add_typed_query(64, '{found: 0, ctime: 0, partner: 0, bad: 1});  // a wall
        add_typed_query(255, '{found: 0, ctime: 0, partner: 0, bad: 1});
        // same velocity as mover 0, and passing the wall wide
        add_row(hsncf_pkg::ACT_LOAD, 1, make_sphere(0, 5 * ONE, 0, ONE, 0, 0, ONE));
        add_row(hsncf_pkg::ACT_QUERY, 1, '0);
        // touching the wall and moving into it: zero root
        add_row(hsncf_pkg::ACT_LOAD, 2, make_sphere(12 * ONE, 0, 0, -ONE, 0, 0, ONE));
        add_row(hsncf_pkg::ACT_QUERY, 2, '0);
        // field extremes
        add_row(hsncf_pkg::ACT_LOAD, 191,
                make_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'hFFFF_FFFF));
        add_row(hsncf_pkg::ACT_LOAD, 63,
                make_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            0));
        add_row(hsncf_pkg::ACT_LOAD, 200, make_sphere(-1, -1, -1, -1, -1, -1, 32'hFFFF_FFFF));
        add_row(hsncf_pkg::ACT_QUERY, 63, '0);
        add_row(hsncf_pkg::ACT_QUERY, 0, '0);
        add_typed_query(191, '{found: 0, ctime: 0, partner: 0, bad: 1});
        add_typed_query(5, '{found: 0, ctime: 0, partner: 0, bad: 1});   // never loaded
        add_typed_query(200, '{found: 0, ctime: 0, partner: 0, bad: 1});
        // very fast mover: times that floor to tiny values
        add_row(hsncf_pkg::ACT_LOAD, 3, make_sphere(3 * ONE, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
        add_row(hsncf_pkg::ACT_QUERY, 3, '0);
        // overlapping pair: only the exit root is positive
        add_row(hsncf_pkg::ACT_LOAD, 65, make_sphere(3 * ONE, 0, 0, 0, 0, 0, ONE));
        add_row(hsncf_pkg::ACT_QUERY, 3, '0);
        add_row(hsncf_pkg::ACT_QUERY, 63, '0);

        @(posedge rst_n);
        foreach (directed[i])
            send(directed[i].act, directed[i].item, directed[i].typed, directed[i].ans);

        // random part, about one query per four transfers
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            it.sphere = random_sphere();
            if ($urandom_range(0, 3) == 0)
            begin
                act = hsncf_pkg::ACT_QUERY;
                it.entry_index = 8'(pick_query_index());
            end
            else
            begin
                act = hsncf_pkg::ACT_LOAD;
                it.entry_index = 8'(pick_load_index());
            end
            send(act, it, 0, none);
        end
        @(negedge clk);
        s_tvalid <= 0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);

        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ----- hard_sphere_next_collision_finder.f -----
hdl/hsncf_pkg.sv
hdl/hsncf_mul.sv
hdl/hsncf_sqrt.sv
hdl/hsncf_dp.sv
hdl/hsncf_ctrl.sv
hdl/hard_sphere_next_collision_finder.sv
tb/testbench.sv
